// ----- src/bwt_pkg.sv -----
// Shared types and constants for the block BWT encoder.
// Used by the rotation comparator and the top level; depends on nothing.
`default_nettype none
package bwt_pkg;

    // Maximum block length and derived widths
    localparam int MAX_BLOCK = 64;
    localparam int ADDR_W    = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int CNT_W     = $clog2(MAX_BLOCK + 1);
    localparam int BYTE_W    = 8;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_PREV,
        S_CMP_GO,
        S_CMP,
        S_PLACE,
        S_EMIT
    } t_state;

    // Rotation compare request and response
    typedef struct packed {
        logic              start;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
    } t_cmp_req;

    typedef struct packed {
        logic done;
        logic gt;
    } t_cmp_rsp;

    // Cyclic increment of a position inside a block of n bytes
    function automatic logic [ADDR_W-1:0] wrap_inc(
        input logic [ADDR_W-1:0] p,
        input logic [CNT_W-1:0]  n
    );
        logic [ADDR_W-1:0] res;
        if (CNT_W'(p) == n - CNT_W'(1)) begin
            res = '0;
        end else begin
            res = p + ADDR_W'(1);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ----- src/bwt_ram.sv -----
// Generic RAM: one write port, two read ports, registered read data.
// Stand-alone; no package needed.
`default_nettype none
module bwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_a,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered reads (read-before-write on collision)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule
`default_nettype wire

// ----- src/bwt_rot_cmp.sv -----
// Rotation comparator: walks two cyclic rotations one byte a cycle.
// Depends on bwt_pkg; reads the block store through two read ports.
`default_nettype none
module bwt_rot_cmp (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire bwt_pkg::t_cmp_req                    i_req,
    input  wire logic [bwt_pkg::CNT_W-1:0]            i_n,
    input  wire logic [bwt_pkg::BYTE_W-1:0]           i_rdata_a,
    input  wire logic [bwt_pkg::BYTE_W-1:0]           i_rdata_b,
    output logic      [bwt_pkg::ADDR_W-1:0]           o_raddr_a,
    output logic      [bwt_pkg::ADDR_W-1:0]           o_raddr_b,
    output bwt_pkg::t_cmp_rsp                         o_rsp
);
    import bwt_pkg::*;

    logic              r_busy, n_busy;
    logic [ADDR_W-1:0] r_pa, n_pa;
    logic [ADDR_W-1:0] r_pb, n_pb;
    logic [ADDR_W-1:0] r_k, n_k;
    logic [ADDR_W-1:0] inc_a, inc_b;
    logic              differ, all_seen;

    // Read address: start positions on request, else the next byte pair
    always_comb begin
        inc_a     = wrap_inc(r_pa, i_n);
        inc_b     = wrap_inc(r_pb, i_n);
        o_raddr_a = i_req.start ? i_req.a : inc_a;
        o_raddr_b = i_req.start ? i_req.b : inc_b;
    end

    // Byte compare on the data read last cycle
    always_comb begin
        differ     = (i_rdata_a != i_rdata_b);
        all_seen   = (CNT_W'(r_k) == i_n - CNT_W'(1));
        o_rsp.done = r_busy && (differ || all_seen);
        o_rsp.gt   = differ && (i_rdata_a > i_rdata_b);
    end

    always_comb begin
        n_busy = r_busy;
        n_pa   = r_pa;
        n_pb   = r_pb;
        n_k    = r_k;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_pa   = i_req.a;
            n_pb   = i_req.b;
            n_k    = '0;
        end else if (r_busy) begin
            if (o_rsp.done) begin
                n_busy = 1'b0;
            end else begin
                n_pa = inc_a;
                n_pb = inc_b;
                n_k  = r_k + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_pa <= n_pa;
        r_pb <= n_pb;
        r_k  <= n_k;
    end

endmodule
`default_nettype wire

// ----- src/block_bwt_encoder_core.sv -----
// Block BWT encoder top level: byte capture, insertion-sort sequencer, output run.
// Throughput: one byte a cycle while filling; busy from the closing byte to the end of the run.
// Sort: each rotation compare passes S_RD_PREV and S_CMP_GO, then walks 1..n byte pairs in S_CMP;
// a start that lands in slot zero is written in a further S_PLACE state.
// Run: n results one a cycle via stages e1 and e2; busy drops after the last beat.
// Synchronous active-low reset returns to idle with an empty block; no clearing pass.
`default_nettype none
module block_bwt_encoder_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [bwt_pkg::BYTE_W-1:0]    i_data_byte,
    input  wire logic                          i_end_of_block,
    output logic                               o_valid,
    output logic      [bwt_pkg::BYTE_W-1:0]    o_out_byte,
    output logic                               o_out_last
);
    import bwt_pkg::*;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_fill, n_fill;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [ADDR_W-1:0] r_i, n_i;
    logic [ADDR_W-1:0] r_j, n_j;
    logic [ADDR_W-1:0] r_prev, n_prev;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic              r_iss_done, n_iss_done;
    logic              r_e1_vld, n_e1_vld, r_e1_last, n_e1_last;
    logic              r_e2_vld, n_e2_vld, r_e2_last, n_e2_last;

    logic              accept, adv_i, issue;
    logic [ADDR_W-1:0] emit_pos;

    // Block store ports
    logic              b_we;
    logic [ADDR_W-1:0] b_waddr, b_raddr_a, b_raddr_b;
    logic [BYTE_W-1:0] b_wdata, b_rdata_a, b_rdata_b;
    // Sorted-start store ports
    logic              s_we;
    logic [ADDR_W-1:0] s_waddr, s_wdata, s_raddr_a, s_raddr_b, s_rdata_a, s_rdata_b;

    t_cmp_req          cmp_req;
    t_cmp_rsp          cmp_rsp;
    logic [ADDR_W-1:0] cmp_raddr_a, cmp_raddr_b;

    bwt_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_BLOCK)) u_block_ram (
        .i_clk     (i_clk),
        .i_we      (b_we),
        .i_waddr   (b_waddr),
        .i_wdata   (b_wdata),
        .i_raddr_a (b_raddr_a),
        .i_raddr_b (b_raddr_b),
        .o_rdata_a (b_rdata_a),
        .o_rdata_b (b_rdata_b)
    );

    bwt_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_BLOCK)) u_sort_ram (
        .i_clk     (i_clk),
        .i_we      (s_we),
        .i_waddr   (s_waddr),
        .i_wdata   (s_wdata),
        .i_raddr_a (s_raddr_a),
        .i_raddr_b (s_raddr_b),
        .o_rdata_a (s_rdata_a),
        .o_rdata_b (s_rdata_b)
    );

    bwt_rot_cmp u_cmp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (cmp_req),
        .i_n       (r_n),
        .i_rdata_a (b_rdata_a),
        .i_rdata_b (b_rdata_b),
        .o_raddr_a (cmp_raddr_a),
        .o_raddr_b (cmp_raddr_b),
        .o_rsp     (cmp_rsp)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // Output beat straight from the block store's registered read
    assign o_valid    = r_e2_vld;
    assign o_out_last = r_e2_last;
    assign o_out_byte = b_rdata_a;

    // Output pipeline: sorted start -> preceding position -> byte
    always_comb begin
        issue     = (r_state == S_EMIT) && !r_iss_done;
        s_raddr_b = r_idx;
        if (s_rdata_b == '0) begin
            emit_pos = ADDR_W'(r_n - CNT_W'(1));
        end else begin
            emit_pos = s_rdata_b - ADDR_W'(1);
        end
        b_raddr_a = (r_state == S_EMIT) ? emit_pos : cmp_raddr_a;
        b_raddr_b = cmp_raddr_b;
        n_e1_vld  = issue;
        n_e1_last = (CNT_W'(r_idx) == r_n - CNT_W'(1));
        n_e2_vld  = r_e1_vld;
        n_e2_last = r_e1_last;
    end

    // Sequencer: capture, insertion sort, run emission
    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_n        = r_n;
        n_i        = r_i;
        n_j        = r_j;
        n_prev     = r_prev;
        n_idx      = r_idx;
        n_iss_done = r_iss_done;
        b_we       = 1'b0;
        b_waddr    = r_fill;
        b_wdata    = i_data_byte;
        s_we       = 1'b0;
        s_waddr    = r_fill;
        s_wdata    = r_fill;
        s_raddr_a  = r_j - ADDR_W'(1);
        cmp_req    = '0;
        adv_i      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    // store byte and seed its start index
                    b_we = 1'b1;
                    s_we = 1'b1;
                    if (i_end_of_block || (CNT_W'(r_fill) == CNT_W'(MAX_BLOCK - 1))) begin
                        n_n    = CNT_W'(r_fill) + CNT_W'(1);
                        n_fill = '0;
                        if (r_fill == '0) begin
                            n_state    = S_EMIT;
                            n_idx      = '0;
                            n_iss_done = 1'b0;
                        end else begin
                            n_i     = ADDR_W'(1);
                            n_j     = ADDR_W'(1);
                            n_state = S_RD_PREV;
                        end
                    end else begin
                        n_fill = r_fill + ADDR_W'(1);
                    end
                end
            end
            S_RD_PREV: begin
                n_state = S_CMP_GO;
            end
            S_CMP_GO: begin
                n_prev        = s_rdata_a;
                cmp_req.start = 1'b1;
                cmp_req.a     = s_rdata_a;
                cmp_req.b     = r_i;
                n_state       = S_CMP;
            end
            S_CMP: begin
                if (cmp_rsp.done) begin
                    s_we    = 1'b1;
                    s_waddr = r_j;
                    if (cmp_rsp.gt) begin
                        // shift the larger start up one slot
                        s_wdata = r_prev;
                        n_j     = r_j - ADDR_W'(1);
                        n_state = (r_j == ADDR_W'(1)) ? S_PLACE : S_RD_PREV;
                    end else begin
                        s_wdata = r_i;
                        adv_i   = 1'b1;
                    end
                end
            end
            S_PLACE: begin
                s_we    = 1'b1;
                s_waddr = '0;
                s_wdata = r_i;
                adv_i   = 1'b1;
            end
            S_EMIT: begin
                if (issue) begin
                    if (n_e1_last) begin
                        n_iss_done = 1'b1;
                    end else begin
                        n_idx = r_idx + ADDR_W'(1);
                    end
                end
                if (r_e2_vld && r_e2_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // next insertion step, or start the run
        if (adv_i) begin
            if (CNT_W'(r_i) == r_n - CNT_W'(1)) begin
                n_state    = S_EMIT;
                n_idx      = '0;
                n_iss_done = 1'b0;
            end else begin
                n_i     = r_i + ADDR_W'(1);
                n_j     = r_i + ADDR_W'(1);
                n_state = S_RD_PREV;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fill     <= '0;
            r_iss_done <= 1'b0;
            r_e1_vld   <= 1'b0;
            r_e2_vld   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_iss_done <= n_iss_done;
            r_e1_vld   <= n_e1_vld;
            r_e2_vld   <= n_e2_vld;
        end
        r_n       <= n_n;
        r_i       <= n_i;
        r_j       <= n_j;
        r_prev    <= n_prev;
        r_idx     <= n_idx;
        r_e1_last <= n_e1_last;
        r_e2_last <= n_e2_last;
    end

`ifndef SYNTHESIS
    // beats come only out of the run state
    a_valid_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_EMIT))
        else $error("output beat outside run state");

    // the final beat of a run releases the block
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_last) |=> !busy)
        else $error("block still busy after final beat");

    // the insertion index never reads below slot zero
    a_j_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD_PREV) |-> (r_j != '0))
        else $error("insertion index underflow");

    // a compare is only started when the sequencer launches one
    a_cmp_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmp_req.start |=> (r_state == S_CMP))
        else $error("compare started outside sort");
`endif

endmodule
`default_nettype wire
